// File: hdl/scef_pkg.sv
package scef_pkg;

  localparam int FREQ_W  = 24;
  localparam int COH_W   = 16;
  localparam int ALPHA_W = 32;
  localparam int GAIN_W  = 40;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 4;

  // Q.60 working values, 1.0 included
  localparam int QW   = 61;
  localparam int FRAC = 60;
  localparam logic [QW-1:0] Q60_ONE = {1'b1, {(QW-1){1'b0}}};

  // Exponent argument t, below 2^56 whenever the result is not saturated
  localparam int TW = 56;
  localparam int KW = 57;
  localparam int DMAX = 34;
  localparam int EW = KW + DMAX;
  localparam int SAT_BIT = 40;

  localparam int HORNER  = 6;
  localparam int NSQ     = 8;
  localparam int MUL_LAT = 3;
  localparam int DIV_CH  = 8;
  localparam int DIV_LAT = TW / DIV_CH;
  localparam int REM_W   = 3;
  localparam int HL      = MUL_LAT + DIV_LAT + 1;

  typedef enum logic {
    REG_DECAY = 1'b0,
    REG_GAIN  = 1'b1
  } reg_sel_t;

  // Eight bits of a long division by a small constant, most significant first.
  function automatic logic [REM_W+DIV_CH-1:0] div_chunk(
    input logic [REM_W-1:0]  rem_in,
    input logic [DIV_CH-1:0] bits,
    input logic [REM_W-1:0]  dvs
  );
    logic [REM_W:0]    r;
    logic [DIV_CH-1:0] q;
    r = {1'b0, rem_in};
    q = '0;
    for (int i = DIV_CH - 1; i >= 0; i--) begin
      r = {r[REM_W-1:0], bits[i]};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        q[i] = 1'b1;
      end
    end
    return {r[REM_W-1:0], q};
  endfunction

endpackage

// File: hdl/scef_delay.sv
module scef_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign q = sh_r[N-1];

endmodule

// File: hdl/scef_mulq60.sv
module scef_mulq60 (
  input  logic                    clk,
  input  logic                    en,
  input  logic [scef_pkg::QW-1:0] a,
  input  logic [scef_pkg::QW-1:0] b,
  output logic [scef_pkg::QW-1:0] y
);

  localparam int QW   = scef_pkg::QW;
  localparam int FRAC = scef_pkg::FRAC;
  localparam int LO   = 31;
  localparam int HI   = QW - LO;
  localparam int FW   = 2 * QW;

  logic [2*LO-1:0]  p00_r;
  logic [LO+HI-1:0] p01_r;
  logic [LO+HI-1:0] p10_r;
  logic [2*HI-1:0]  p11_r;
  logic [2*LO-1:0]  q00_r;
  logic [LO+HI:0]   mid_r;
  logic [2*HI-1:0]  q11_r;
  logic [FW-1:0]    full;
  logic [QW-1:0]    y_r;

  always_comb begin
    full = {q11_r, {(2*LO){1'b0}}} + (FW'(mid_r) << LO) + FW'(q00_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= (2*LO)'(a[LO-1:0]) * (2*LO)'(b[LO-1:0]);
      p01_r <= (LO+HI)'(a[LO-1:0]) * (LO+HI)'(b[QW-1:LO]);
      p10_r <= (LO+HI)'(a[QW-1:LO]) * (LO+HI)'(b[LO-1:0]);
      p11_r <= (2*HI)'(a[QW-1:LO]) * (2*HI)'(b[QW-1:LO]);
      q00_r <= p00_r;
      q11_r <= p11_r;
      mid_r <= (LO+HI+1)'(p01_r) + (LO+HI+1)'(p10_r);
      y_r   <= full[FRAC+QW-1:FRAC];
    end
  end

  assign y = y_r;

endmodule

// File: hdl/scef_divc.sv
module scef_divc #(
  parameter int DIVISOR = 3
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [scef_pkg::TW-1:0] x,
  output logic [scef_pkg::TW-1:0] q
);

  localparam int TW     = scef_pkg::TW;
  localparam int NST    = scef_pkg::DIV_LAT;
  localparam int DIV_CH = scef_pkg::DIV_CH;
  localparam int REM_W  = scef_pkg::REM_W;
  localparam logic [REM_W-1:0] DVS = REM_W'(DIVISOR);

  logic [TW-1:0]    x_r   [NST-1];
  logic [REM_W-1:0] rem_r [NST-1];
  logic [TW-1:0]    q_r   [NST];

  for (genvar j = 0; j < NST; j++) begin : g_st
    logic [TW-1:0]           x_in;
    logic [TW-1:0]           q_in;
    logic [REM_W-1:0]        rem_in;
    logic [REM_W+DIV_CH-1:0] res;
    logic [TW-1:0]           q_nxt;

    if (j == 0) begin : g_first
      assign x_in   = x;
      assign q_in   = '0;
      assign rem_in = '0;
    end else begin : g_next
      assign x_in   = x_r[j-1];
      assign q_in   = q_r[j-1];
      assign rem_in = rem_r[j-1];
    end

    assign res = scef_pkg::div_chunk(rem_in, x_in[TW-1-DIV_CH*j -: DIV_CH], DVS);

    always_comb begin
      q_nxt = q_in;
      q_nxt[TW-1-DIV_CH*j -: DIV_CH] = res[DIV_CH-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j] <= q_nxt;
      end
    end

    if (j < NST - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[j]   <= x_in;
          rem_r[j] <= res[REM_W+DIV_CH-1:DIV_CH];
        end
      end
    end
  end

  assign q = q_r[NST-1];

endmodule

// File: hdl/scef_isqrt.sv
module scef_isqrt #(
  parameter int SW = 50,
  parameter int DW = 25
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] s,
  output logic [DW-1:0] root
);

  logic [SW-1:0] rem_r  [DW-1];
  logic [DW-1:0] root_r [DW];

  // One result bit per stage; the remainder holds s minus the root squared.
  for (genvar j = 0; j < DW; j++) begin : g_st
    localparam int B = DW - 1 - j;
    logic [SW-1:0] rem_in;
    logic [DW-1:0] root_in;
    logic [SW-1:0] trial;
    logic          hit;

    if (j == 0) begin : g_first
      assign rem_in  = s;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end

    assign trial = (SW'(root_in) << (B + 1)) + (SW'(1) << (2 * B));
    assign hit   = (trial <= rem_in);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[j] <= hit ? (root_in | (DW'(1) << B)) : root_in;
      end
    end

    if (j < DW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= hit ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  assign root = root_r[DW-1];

endmodule

// File: hdl/scef_front.sv
module scef_front #(
  parameter int CW = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [CW-1:0]               first_x,
  input  logic [CW-1:0]               first_y,
  input  logic [CW-1:0]               first_z,
  input  logic [CW-1:0]               second_x,
  input  logic [CW-1:0]               second_y,
  input  logic [CW-1:0]               second_z,
  input  logic [scef_pkg::FREQ_W-1:0] freq,
  output logic                        q_valid,
  input  logic                        q_take,
  output logic [CW-1:0]               q_dx,
  output logic [CW-1:0]               q_dy,
  output logic [CW-1:0]               q_dz,
  output logic [scef_pkg::FREQ_W-1:0] q_freq
);

  localparam int FREQ_W = scef_pkg::FREQ_W;
  localparam int QD = 2;

  logic [CW:0]   dfx, dfy, dfz;
  logic [CW-1:0] mx, my, mz;
  logic          wr, rd;

  logic [CW-1:0]     ex_r [QD];
  logic [CW-1:0]     ey_r [QD];
  logic [CW-1:0]     ez_r [QD];
  logic [FREQ_W-1:0] ef_r [QD];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;

  // Only the magnitude of each axis difference matters once it is squared.
  assign dfx = {first_x[CW-1], first_x} - {second_x[CW-1], second_x};
  assign dfy = {first_y[CW-1], first_y} - {second_y[CW-1], second_y};
  assign dfz = {first_z[CW-1], first_z} - {second_z[CW-1], second_z};

  always_comb begin
    mx = dfx[CW] ? CW'(-dfx) : dfx[CW-1:0];
    my = dfy[CW] ? CW'(-dfy) : dfy[CW-1:0];
    mz = dfz[CW] ? CW'(-dfz) : dfz[CW-1:0];
  end

  assign full    = (cnt_r == 2'(QD));
  assign q_valid = (cnt_r != 2'd0);
  assign wr      = push && !full;
  assign rd      = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      ex_r[wp_r] <= mx;
      ey_r[wp_r] <= my;
      ez_r[wp_r] <= mz;
      ef_r[wp_r] <= freq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        wp_r <= !wp_r;
      end
      if (rd) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

  assign q_dx   = ex_r[rp_r];
  assign q_dy   = ey_r[rp_r];
  assign q_dz   = ez_r[rp_r];
  assign q_freq = ef_r[rp_r];

endmodule

// File: hdl/scef_back.sv
module scef_back #(
  parameter int CW = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_take,
  input  logic [CW-1:0]                dx,
  input  logic [CW-1:0]                dy,
  input  logic [CW-1:0]                dz,
  input  logic [scef_pkg::FREQ_W-1:0]  freq,
  input  logic [scef_pkg::ALPHA_W-1:0] alpha,
  input  logic [scef_pkg::GAIN_W-1:0]  gain,
  output logic                         empty,
  input  logic                         pop,
  output logic [scef_pkg::COH_W-1:0]   coherence
);

  localparam int QW      = scef_pkg::QW;
  localparam int TW      = scef_pkg::TW;
  localparam int KW      = scef_pkg::KW;
  localparam int EW      = scef_pkg::EW;
  localparam int DMAX    = scef_pkg::DMAX;
  localparam int COH_W   = scef_pkg::COH_W;
  localparam int ALPHA_W = scef_pkg::ALPHA_W;
  localparam int GAIN_W  = scef_pkg::GAIN_W;
  localparam int FREQ_W  = scef_pkg::FREQ_W;
  localparam int HORNER  = scef_pkg::HORNER;
  localparam int NSQ     = scef_pkg::NSQ;
  localparam int SAT_BIT = scef_pkg::SAT_BIT;
  localparam int DW      = CW + 1;
  localparam int SW      = 2 * CW + 2;
  localparam int F2W     = 2 * FREQ_W;
  localparam int GH      = GAIN_W / 2;
  localparam int FH      = FREQ_W;
  localparam int PW      = GH + FH;
  localparam int BFW     = GAIN_W + F2W;
  localparam int KLO     = 29;
  localparam int DLO     = 17;
  localparam int EPW     = KLO + DLO;
  localparam int SAT_DLY = HORNER * scef_pkg::HL + NSQ * scef_pkg::MUL_LAT;
  localparam int LAT     = 4 + DW + SAT_DLY + 1;
  localparam int OD      = 2;
  localparam int RND_BIT = scef_pkg::FRAC - COH_W + 1;

  logic adv;

  logic [2*CW-1:0] sqx_r, sqy_r, sqz_r;
  logic [F2W-1:0]  f2_r;
  logic [SW-1:0]   s_r;
  logic [PW-1:0]   pa_r, pb_r, pc_r, pd_r;
  logic [BFW-1:0]  bf_r;
  logic [KW-1:0]   k_r, kd;
  logic [DW-1:0]   d;
  logic [DMAX-1:0] dzx;
  logic [EPW-1:0]  ea_r, eb_r, ec_r, ed_r;
  logic [EW-1:0]   e;
  logic            sat_r, satd;
  logic [TW-1:0]   t_r;
  logic [QW-1:0]   rnd;
  logic [COH_W-1:0] coh_r;

  logic [LAT-1:0] vld_r;

  logic [TW-1:0] h_t  [HORNER+1];
  logic [QW-1:0] h_s  [HORNER+1];
  logic [QW-1:0] sq_s [NSQ+1];

  logic [COH_W-1:0] ob_r [OD];
  logic             owp_r, orp_r;
  logic [1:0]       ocnt_r;
  logic             opush, opop;

  // The whole datapath moves together while the result queue has room.
  assign adv    = (ocnt_r != 2'(OD));
  assign q_take = adv && q_valid;

  // Squares, f^2; then distance squared, b*f^2 partials; then b*f^2; then k.
  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r <= (2*CW)'(dx) * (2*CW)'(dx);
      sqy_r <= (2*CW)'(dy) * (2*CW)'(dy);
      sqz_r <= (2*CW)'(dz) * (2*CW)'(dz);
      f2_r  <= F2W'(freq) * F2W'(freq);
      s_r   <= SW'(sqx_r) + SW'(sqy_r) + SW'(sqz_r);
      pa_r  <= PW'(gain[GAIN_W-1:GH]) * PW'(f2_r[F2W-1:FH]);
      pb_r  <= PW'(gain[GAIN_W-1:GH]) * PW'(f2_r[FH-1:0]);
      pc_r  <= PW'(gain[GH-1:0]) * PW'(f2_r[F2W-1:FH]);
      pd_r  <= PW'(gain[GH-1:0]) * PW'(f2_r[FH-1:0]);
      bf_r  <= (BFW'(pa_r) << (GH + FH)) + (BFW'(pb_r) << GH)
             + (BFW'(pc_r) << FH) + BFW'(pd_r);
      k_r   <= KW'(alpha) + KW'(bf_r[BFW-1:32]);
    end
  end

  scef_isqrt #(.SW(SW), .DW(DW)) u_sqrt (
    .clk  (clk),
    .en   (adv),
    .s    (s_r),
    .root (d)
  );

  scef_delay #(.W(KW), .N(DW - 2)) u_kdly (
    .clk (clk),
    .en  (adv),
    .d   (k_r),
    .q   (kd)
  );

  assign dzx = DMAX'(d);
  assign e   = (EW'(ea_r) << (KLO + DLO)) + (EW'(eb_r) << KLO)
             + (EW'(ec_r) << DLO) + EW'(ed_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      ea_r  <= EPW'(kd[KW-1:KLO]) * EPW'(dzx[DMAX-1:DLO]);
      eb_r  <= EPW'(kd[KW-1:KLO]) * EPW'(dzx[DLO-1:0]);
      ec_r  <= EPW'(kd[KLO-1:0]) * EPW'(dzx[DMAX-1:DLO]);
      ed_r  <= EPW'(kd[KLO-1:0]) * EPW'(dzx[DLO-1:0]);
      // Beyond an exponent of 16 the result is below one LSB.
      sat_r <= |e[EW-1:SAT_BIT];
      t_r   <= {e[SAT_BIT-1:0], (TW-SAT_BIT)'(0)};
    end
  end

  // exp(-t) by a Horner series in t, with t already scaled down by 256.
  assign h_t[0] = t_r;
  assign h_s[0] = scef_pkg::Q60_ONE;

  for (genvar g = 0; g < HORNER; g++) begin : g_horner
    logic [QW-1:0] hm;
    logic [TW-1:0] hq;
    logic [QW-1:0] hs_r;

    scef_mulq60 u_mul (
      .clk (clk),
      .en  (adv),
      .a   (QW'(h_t[g])),
      .b   (h_s[g]),
      .y   (hm)
    );

    scef_divc #(.DIVISOR(HORNER - g)) u_div (
      .clk (clk),
      .en  (adv),
      .x   (hm[TW-1:0]),
      .q   (hq)
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        hs_r <= scef_pkg::Q60_ONE - QW'(hq);
      end
    end

    assign h_s[g+1] = hs_r;

    if (g < HORNER - 1) begin : g_tdly
      scef_delay #(.W(TW), .N(scef_pkg::HL)) u_tdly (
        .clk (clk),
        .en  (adv),
        .d   (h_t[g]),
        .q   (h_t[g+1])
      );
    end else begin : g_tend
      assign h_t[g+1] = h_t[g];
    end
  end

  // Undo the scaling: eight successive squarings.
  assign sq_s[0] = h_s[HORNER];

  for (genvar n = 0; n < NSQ; n++) begin : g_square
    scef_mulq60 u_sq (
      .clk (clk),
      .en  (adv),
      .a   (sq_s[n]),
      .b   (sq_s[n]),
      .y   (sq_s[n+1])
    );
  end

  scef_delay #(.W(1), .N(SAT_DLY)) u_sdly (
    .clk (clk),
    .en  (adv),
    .d   (sat_r),
    .q   (satd)
  );

  assign rnd = sq_s[NSQ] + (QW'(1) << (RND_BIT - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      coh_r <= satd ? '0 : rnd[RND_BIT+COH_W-1:RND_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], q_take};
    end
  end

  assign opush = adv && vld_r[LAT-1];
  assign opop  = pop && (ocnt_r != 2'd0);
  assign empty = (ocnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (opush) begin
      ob_r[owp_r] <= coh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (opush) begin
        owp_r <= !owp_r;
      end
      if (opop) begin
        orp_r <= !orp_r;
      end
      ocnt_r <= ocnt_r + 2'(opush) - 2'(opop);
    end
  end

  assign coherence = ob_r[orp_r];

endmodule

// File: hdl/spatial_coherence_exp_decay.sv
// Loh-Lin spatial coherence: exp(-(alpha + b*f^2) * d) between two stations.
// Input queue: drive the six station coordinates and freq with push; the
// transaction is taken on a clock edge where push is high and full is low.
// Result queue: while empty is low, out_coherence holds the oldest result
// (Q1.15, 32768 is 1.0); pop on that edge removes it.
// Configuration: APB-style, alpha at byte address 0, b at byte address 8,
// both readable; write them only while no transaction is in flight.
// Throughput is one transaction per cycle while the result queue has room.
// An accepted input reaches its result through the bit-per-stage square
// root (COORD_WIDTH + 1 stages), six Horner steps (each a multiplier plus a
// constant divider that takes one byte per stage) and eight squaring
// multipliers.
// A two-entry queue separates the input side from the datapath, and the
// datapath feeds a two-entry result queue. When the receiver stops popping,
// the datapath freezes once the result queue is full and full then rises
// at the input after the front queue fills.
// Synchronous reset empties both queues and clears alpha and b to zero.
module spatial_coherence_exp_decay #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [COORD_WIDTH-1:0]       in_first_x,
  input  logic [COORD_WIDTH-1:0]       in_first_y,
  input  logic [COORD_WIDTH-1:0]       in_first_z,
  input  logic [COORD_WIDTH-1:0]       in_second_x,
  input  logic [COORD_WIDTH-1:0]       in_second_y,
  input  logic [COORD_WIDTH-1:0]       in_second_z,
  input  logic [scef_pkg::FREQ_W-1:0]  in_freq,
  output logic                         empty,
  input  logic                         pop,
  output logic [scef_pkg::COH_W-1:0]   out_coherence,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scef_pkg::ADDR_W-1:0]  paddr,
  input  logic [scef_pkg::DATA_W-1:0]  pwdata,
  output logic [scef_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int CW      = COORD_WIDTH;
  localparam int FREQ_W  = scef_pkg::FREQ_W;
  localparam int ALPHA_W = scef_pkg::ALPHA_W;
  localparam int GAIN_W  = scef_pkg::GAIN_W;
  localparam int DATA_W  = scef_pkg::DATA_W;

  logic [ALPHA_W-1:0] alpha_r;
  logic [GAIN_W-1:0]  gain_r;
  logic               cfg_wr;
  scef_pkg::reg_sel_t sel;

  logic              q_valid, q_take;
  logic [CW-1:0]     q_dx, q_dy, q_dz;
  logic [FREQ_W-1:0] q_freq;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  // Registers sit on 8-byte boundaries; the low address bits are ignored.
  assign sel    = scef_pkg::reg_sel_t'(paddr[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= '0;
      gain_r  <= '0;
    end else if (cfg_wr) begin
      unique case (sel)
        scef_pkg::REG_DECAY: alpha_r <= pwdata[ALPHA_W-1:0];
        scef_pkg::REG_GAIN:  gain_r  <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      scef_pkg::REG_DECAY: prdata = DATA_W'(alpha_r);
      scef_pkg::REG_GAIN:  prdata = DATA_W'(gain_r);
      default:             prdata = '0;
    endcase
  end

  scef_front #(.CW(CW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .first_z  (in_first_z),
    .second_x (in_second_x),
    .second_y (in_second_y),
    .second_z (in_second_z),
    .freq     (in_freq),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_dx     (q_dx),
    .q_dy     (q_dy),
    .q_dz     (q_dz),
    .q_freq   (q_freq)
  );

  scef_back #(.CW(CW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .dx        (q_dx),
    .dy        (q_dy),
    .dz        (q_dz),
    .freq      (q_freq),
    .alpha     (alpha_r),
    .gain      (gain_r),
    .empty     (empty),
    .pop       (pop),
    .coherence (out_coherence)
  );

endmodule

// File: hdl/scef_checker.sv
module scef_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [scef_pkg::COH_W-1:0]  out_coherence,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [scef_pkg::ADDR_W-1:0] paddr,
  input logic [scef_pkg::DATA_W-1:0] pwdata,
  input logic [scef_pkg::DATA_W-1:0] prdata
);

  localparam logic [scef_pkg::COH_W-1:0] COH_MAX = 16'd32768;

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  a_coh_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_coherence <= COH_MAX))
    else $error("coherence above 1.0");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_coherence)))
    else $error("waiting result lost or changed");

  // A write to alpha reads back on the following cycle.
  a_alpha_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && !paddr[3]) ##1 !paddr[3]
      |-> (prdata == {32'd0, $past(pwdata[31:0])}))
    else $error("alpha readback mismatch");

endmodule

bind spatial_coherence_exp_decay scef_checker u_scef_checker (.*);

// File: verif/tb_spatial_coherence_exp_decay.sv
`timescale 1ns / 1ps

module tb_spatial_coherence_exp_decay;

  localparam int CW          = 24;
  localparam int PIPE_LAT    = CW + 97;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_ITEMS = 108;
  localparam int NO_CHECK    = -1;

  typedef struct {
    logic [CW-1:0]               ax, ay, az, bx, by, bz;
    logic [scef_pkg::FREQ_W-1:0] freq;
  } station_pair_t;

  typedef struct {
    bit            set_cfg;
    logic [31:0]   alpha;
    logic [39:0]   gain;
    station_pair_t pair;
    int            coh;
  } stim_row_t;

  logic clk, rst_n;
  logic push, full, empty, pop;
  logic [CW-1:0]               in_first_x, in_first_y, in_first_z;
  logic [CW-1:0]               in_second_x, in_second_y, in_second_z;
  logic [scef_pkg::FREQ_W-1:0] in_freq;
  logic [scef_pkg::COH_W-1:0]  out_coherence;
  logic psel, penable, pwrite, pready;
  logic [scef_pkg::ADDR_W-1:0] paddr;
  logic [scef_pkg::DATA_W-1:0] pwdata, prdata;

  logic [31:0] alpha_cfg;
  logic [39:0] gain_cfg;
  logic [15:0] coherence_q[$];
  int errors, received, sent, cycles;
  bit sender_busy_stretch;

  spatial_coherence_exp_decay #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_first_x(in_first_x), .in_first_y(in_first_y), .in_first_z(in_first_z),
    .in_second_x(in_second_x), .in_second_y(in_second_y), .in_second_z(in_second_z),
    .in_freq(in_freq), .empty(empty), .pop(pop), .out_coherence(out_coherence),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Fixed-point coherence for one station pair under the current alpha and b.
  function automatic logic [15:0] predict_coherence(station_pair_t p);
    longint      ddx, ddy, ddz;
    logic [63:0] sq, root, cand, f2, k, t, s;
    logic [127:0] prod;
    ddx = longint'($signed(p.ax)) - longint'($signed(p.bx));
    ddy = longint'($signed(p.ay)) - longint'($signed(p.by));
    ddz = longint'($signed(p.az)) - longint'($signed(p.bz));
    sq = ddx * ddx + ddy * ddy + ddz * ddz;
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      prod = {64'd0, cand} * {64'd0, cand};
      if (prod <= {64'd0, sq}) root = cand;
    end
    f2 = 64'(p.freq) * 64'(p.freq);
    prod = {88'd0, gain_cfg} * {64'd0, f2};
    k = 64'(alpha_cfg) + prod[95:32];
    prod = {64'd0, k} * {64'd0, root};
    if (prod >= (128'd16 << 36)) return 16'd0;
    t = prod[63:0] << 16;
    s = 64'd1 << 60;
    for (int i = 6; i >= 1; i--) begin
      prod = {64'd0, t} * {64'd0, s};
      s = (64'd1 << 60) - prod[123:60] / 64'(i);
    end
    for (int i = 0; i < 8; i++) begin
      prod = {64'd0, s} * {64'd0, s};
      s = prod[123:60];
    end
    s = (s + (64'd1 << 44)) >> 45;
    return s[15:0];
  endfunction

  task automatic write_reg(scef_pkg::reg_sel_t sel, logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= scef_pkg::ADDR_W'({sel, 3'b000});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    while (coherence_q.size() != 0) @(posedge clk);
  endtask

  task automatic reconfigure(logic [31:0] alpha, logic [39:0] gain);
    // Stop offering the last pair before waiting for the block to empty.
    push <= 1'b0;
    drain();
    write_reg(scef_pkg::REG_DECAY, 64'(alpha));
    write_reg(scef_pkg::REG_GAIN, 64'(gain));
    alpha_cfg = alpha;
    gain_cfg  = gain;
  endtask

  // Offers one pair and returns once the block has taken it.
  task automatic send_pair(station_pair_t p, int coh);
    int gap;
    gap = 0;
    if (!sender_busy_stretch && $urandom_range(99) < 45) gap = 1;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    in_first_x  <= p.ax;
    in_first_y  <= p.ay;
    in_first_z  <= p.az;
    in_second_x <= p.bx;
    in_second_y <= p.by;
    in_second_z <= p.bz;
    in_freq     <= p.freq;
    do @(posedge clk); while (full);
    coherence_q.push_back(coh == NO_CHECK ? predict_coherence(p) : 16'(coh));
    sent++;
  endtask

  function automatic logic [CW-1:0] near_coord(logic [CW-1:0] base);
    int mag;
    mag = $urandom_range(0, 1 << $urandom_range(0, 12));
    return $urandom_range(1) ? base + CW'(mag) : base - CW'(mag);
  endfunction

  function automatic station_pair_t random_pair();
    station_pair_t p;
    p.ax = CW'($urandom);
    p.ay = CW'($urandom);
    p.az = CW'($urandom);
    if ($urandom_range(99) < 10) begin
      p.bx = CW'($urandom);
      p.by = CW'($urandom);
      p.bz = CW'($urandom);
    end else begin
      p.bx = near_coord(p.ax);
      p.by = near_coord(p.ay);
      p.bz = near_coord(p.az);
    end
    p.freq = scef_pkg::FREQ_W'($urandom) >> $urandom_range(0, scef_pkg::FREQ_W - 1);
    return p;
  endfunction

  stim_row_t directed[$];

  function automatic stim_row_t row(bit set_cfg, logic [31:0] alpha, logic [39:0] gain,
                                    logic [CW-1:0] ax, logic [CW-1:0] ay, logic [CW-1:0] az,
                                    logic [CW-1:0] bx, logic [CW-1:0] by, logic [CW-1:0] bz,
                                    logic [scef_pkg::FREQ_W-1:0] freq, int coh);
    stim_row_t r;
    r.set_cfg = set_cfg;
    r.alpha   = alpha;
    r.gain    = gain;
    r.pair    = '{ax, ay, az, bx, by, bz, freq};
    r.coh     = coh;
    return r;
  endfunction

  // Result side: checks every popped transaction and stalls at random.
  initial begin
    int hold_left;
    hold_left = 0;
    pop <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (coherence_q.size() == 0) begin
          $display("%0t: result %0d arrived with none expected", $time, out_coherence);
          errors++;
        end else begin
          logic [15:0] want;
          want = coherence_q.pop_front();
          if (out_coherence !== want) begin
            $display("%0t: coherence expected %0d, got %0d", $time, want, out_coherence);
            errors++;
          end
        end
        received++;
        // Once, stop popping long enough for the block to back up to its input.
        if (received == 150) hold_left = 400;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (received >= 250 && received < 350) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 31);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    received = 0;
    sent = 0;
    sender_busy_stretch = 1'b0;
    alpha_cfg = '0;
    gain_cfg  = '0;
    rst_n <= 1'b0;
    push <= 1'b0;
    in_first_x <= '0; in_first_y <= '0; in_first_z <= '0;
    in_second_x <= '0; in_second_y <= '0; in_second_z <= '0;
    in_freq <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;

    // With alpha and b at their reset value of zero every pair gives exactly one.
    directed.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32768));
    directed.push_back(row(0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                           24'h800000, 24'h800000, 24'h800000, 24'hFFFFFF, 32768));
    directed.push_back(row(0, 0, 0, 24'h800000, 24'h800000, 24'h800000,
                           24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 32768));
    directed.push_back(row(0, 0, 0, 24'h123456, 24'hABCDEF, 24'h000001,
                           24'hFEDCBA, 24'h654321, 24'hFFFFFF, 24'h000FFF, 32768));
    // Both registers at their maximum.
    directed.push_back(row(1, 32'hFFFFFFFF, 40'hFFFFFFFFFF, 24'h7FFFFF, 24'h800000,
                           24'h5A5A5A, 24'h7FFFFF, 24'h800000, 24'h5A5A5A, 24'hFFFFFF, 32768));
    directed.push_back(row(0, 0, 0, 0, 0, 0, 24'h7FFFFF, 0, 0, 0, 0));
    directed.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 24'h000001, 0, NO_CHECK));
    directed.push_back(row(0, 0, 0, 0, 0, 0, 1, 0, 0, 24'hFFFFFF, 0));
    // alpha of one half: 32 m is the first distance that saturates.
    directed.push_back(row(1, 32'h80000000, 0, 0, 0, 0, 0, 0, 24'd256, 24'h000123, NO_CHECK));
    directed.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 24'd512, 0, 0));
    directed.push_back(row(0, 0, 0, 0, 0, 24'd511, 0, 0, 0, 0, NO_CHECK));
    directed.push_back(row(0, 0, 0, 24'hFFFFF0, 0, 0, 24'h000010, 0, 0, 0, NO_CHECK));
    // Frequency-only decay: b = 2^-20 at 1024 Hz gives one per metre.
    directed.push_back(row(1, 0, 40'h0000100000, 0, 0, 0, 24'd16, 0, 0, 24'h400000, NO_CHECK));
    directed.push_back(row(0, 0, 0, 0, 0, 0, 24'd16, 0, 0, 0, 32768));
    directed.push_back(row(0, 0, 0, 0, 24'h800000, 0, 0, 24'h800010, 0, 24'h7FFFFF, NO_CHECK));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].set_cfg) reconfigure(directed[i].alpha, directed[i].gain);
      send_pair(directed[i].pair, directed[i].coh);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      logic [31:0] alpha;
      logic [39:0] gain;
      alpha = $urandom >> $urandom_range(0, 12);
      gain  = {8'($urandom), 32'($urandom)} >> $urandom_range(0, 39);
      if (ph == RAND_PHASES - 1) begin
        alpha = $urandom;
        gain  = {8'($urandom), 32'($urandom)};
      end
      reconfigure(alpha, gain);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sender_busy_stretch = (ph == 2);
        send_pair(random_pair(), NO_CHECK);
      end
    end
    sender_busy_stretch = 1'b0;
    push <= 1'b0;

    drain();
    repeat (PIPE_LAT + 30) @(posedge clk);
    $display("Sent %0d station pairs over %0d register settings, %0d results checked.",
             sent, RAND_PHASES + 4, received);
    $display("Covered reset values, register extremes, coincident stations and saturation.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
